FILE: design/pgalloc_pkg.sv
package pgalloc_pkg;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_INCREF = 2'd2,
    CMD_DONATE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OOM      = 3'd1,
    ST_BAD_ADDR = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_UNREF    = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_TABLE_BASE   = 2'd0,
    REG_FIRST_USABLE = 2'd1,
    REG_TOP          = 2'd2
  } reg_idx_e;

  localparam int unsigned AddrW = 32;
  localparam int unsigned CountW = 8;
  localparam logic [CountW-1:0] CountMax = '1;

  // classified item passed from front to back
  typedef struct packed {
    cmd_e             cmd;
    logic [AddrW-1:0] addr;
    logic             addr_ok;
  } item_t;

endpackage

FILE: design/pgalloc_ram.sv
module pgalloc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/pgalloc_front.sv
module pgalloc_front #(
  parameter int unsigned NUM_PAGES  = 32768,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  pgalloc_pkg::cmd_e         cmd_i,
  input  logic [31:0]               addr_i,
  input  logic [31:0]               base_i,
  input  logic [31:0]               first_usable_i,
  input  logic [31:0]               top_i,
  input  logic                      clearing_i,
  input  logic                      pop_i,
  output logic                      head_valid_o,
  output pgalloc_pkg::item_t        head_o
);
  import pgalloc_pkg::*;

  item_t       q_mem_q [2];
  logic        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push;
  logic [31:0] diff, pg;
  item_t       item_in;

  assign busy = (count_q == 2'd2) || clearing_i;
  assign push = start && !busy;

  always_comb begin
    diff            = addr_i - base_i;
    pg              = diff >> PAGE_SHIFT;
    item_in.cmd     = cmd_i;
    item_in.addr    = addr_i;
    item_in.addr_ok = (addr_i[PAGE_SHIFT-1:0] == '0) &&
                      (addr_i >= first_usable_i) && (addr_i < top_i) &&
                      (addr_i >= base_i) && (pg < 32'(NUM_PAGES));
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= item_in;
    end
  end

  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = q_mem_q[rd_ptr_q];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("item queue overrun");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != 2'd0) else $error("pop from empty item queue");
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_i |=> $past(!push)) else $error("item taken during count clear");

endmodule

FILE: design/pgalloc_back.sv
module pgalloc_back #(
  parameter int unsigned NUM_PAGES  = 32768,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [31:0]            base_i,
  input  logic                   head_valid_i,
  input  pgalloc_pkg::item_t     head_i,
  output logic                   pop_o,
  output logic                   clearing_o,
  output logic                   valid_o,
  output logic [31:0]            page_addr_o,
  output logic [7:0]             ref_count_o,
  output logic                   released_o,
  output pgalloc_pkg::status_e   status_o
);
  import pgalloc_pkg::*;

  localparam int unsigned IdxW   = $clog2(NUM_PAGES);
  localparam int unsigned DepthW = $clog2(NUM_PAGES + 1);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [IdxW-1:0]   clr_q, clr_d;
  logic [DepthW-1:0] depth_q, depth_d;
  item_t             cur_q, cur_d;
  logic [IdxW-1:0]   idx_q, idx_d;

  logic              valid_d;
  logic [31:0]       page_d;
  logic [7:0]        cnt_d;
  logic              rel_d;
  status_e           st_d;

  logic              cnt_we, stk_we;
  logic [IdxW-1:0]   cnt_waddr, cnt_raddr, stk_raddr;
  logic [7:0]        cnt_wdata, cnt_rdata;
  logic [IdxW-1:0]   stk_rdata;
  logic [31:0]       head_diff, head_pg;
  logic              full, empty;
  logic [7:0]        cnt_dec;

  pgalloc_ram #(.WIDTH(CountW), .DEPTH(NUM_PAGES)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  pgalloc_ram #(.WIDTH(IdxW), .DEPTH(NUM_PAGES)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (depth_q[IdxW-1:0]),
    .wdata_i (idx_q),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign head_diff  = head_i.addr - base_i;
  assign head_pg    = head_diff >> PAGE_SHIFT;
  assign full       = (depth_q == DepthW'(NUM_PAGES));
  assign empty      = (depth_q == '0);
  assign cnt_raddr  = head_pg[IdxW-1:0];
  assign stk_raddr  = IdxW'(depth_q - DepthW'(1));
  assign clearing_o = (state_q == S_CLEAR);
  assign cnt_dec    = cnt_rdata - 8'd1;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    depth_d   = depth_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    pop_o     = 1'b0;
    cnt_we    = 1'b0;
    cnt_waddr = idx_q;
    cnt_wdata = '0;
    stk_we    = 1'b0;
    valid_d   = 1'b0;
    page_d    = cur_q.addr;
    cnt_d     = '0;
    rel_d     = 1'b0;
    st_d      = ST_OK;
    unique case (state_q)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        clr_d     = clr_q + IdxW'(1);
        if (clr_q == IdxW'(NUM_PAGES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head_valid_i) begin
          pop_o   = 1'b1;
          cur_d   = head_i;
          idx_d   = head_pg[IdxW-1:0];
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        valid_d = 1'b1;
        state_d = S_IDLE;
        if (cur_q.cmd == CMD_ALLOC) begin
          if (empty) begin
            page_d = '0;
            st_d   = ST_OOM;
          end else begin
            depth_d   = depth_q - DepthW'(1);
            cnt_we    = 1'b1;
            cnt_waddr = stk_rdata;
            cnt_wdata = 8'd1;
            cnt_d     = 8'd1;
            page_d    = base_i + (32'(stk_rdata) << PAGE_SHIFT);
          end
        end else if (!cur_q.addr_ok) begin
          st_d = ST_BAD_ADDR;
        end else begin
          case (cur_q.cmd)
            CMD_FREE: begin
              if (cnt_rdata == '0) begin
                st_d = ST_UNREF;
              end else begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_dec;
                cnt_d     = cnt_dec;
                if (cnt_dec == '0) begin
                  if (full) begin
                    st_d = ST_FULL;
                  end else begin
                    stk_we  = 1'b1;
                    depth_d = depth_q + DepthW'(1);
                    rel_d   = 1'b1;
                  end
                end
              end
            end
            CMD_INCREF: begin
              cnt_d = cnt_rdata;
              if (cnt_rdata == CountMax) begin
                st_d = ST_OVERFLOW;
              end else begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_rdata + 8'd1;
                cnt_d     = cnt_rdata + 8'd1;
              end
            end
            default: begin
              if (full) begin
                cnt_d = cnt_rdata;
                st_d  = ST_FULL;
              end else begin
                cnt_we  = 1'b1;
                stk_we  = 1'b1;
                depth_d = depth_q + DepthW'(1);
                rel_d   = 1'b1;
              end
            end
          endcase
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      depth_q <= '0;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      depth_q <= depth_d;
      valid_o <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    idx_q <= idx_d;
    if (valid_d) begin
      page_addr_o <= page_d;
      ref_count_o <= cnt_d;
      released_o  <= rel_d;
      status_o    <= st_d;
    end
  end

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepthW'(NUM_PAGES)) else $error("free stack depth past capacity");
  a_exec_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> state_q == S_IDLE && valid_o) else $error("item not retired");
  a_release_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && released_o |-> status_o == ST_OK) else $error("release with error status");
  a_push_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_we |=> depth_q == $past(depth_q) + DepthW'(1)) else $error("push lost");

endmodule

FILE: design/page_allocator_with_refcount.sv
// channel   | signals                                   | handshake
// ----------+-------------------------------------------+-------------------------
// command   | cmd_i, addr_i                             | start & !busy
// result    | page_addr_o, ref_count_o, released_o,     | valid_o, one cycle
//           | status_o                                  |
// config    | cfg_idx_i, cfg_data_i                     | cfg_we_i
//
// In the back end, IDLE pops an item and reads the count/stack RAM, then EXEC
// modifies, writes back and registers the result together with valid_o.
// A two-entry item queue lets the front take commands while the back works.
// After reset the count RAM is cleared one entry a cycle, all NUM_PAGES
// entries; busy stays high meanwhile. The receiver cannot stall results.
module page_allocator_with_refcount #(
  parameter int unsigned NUM_PAGES  = 32768,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  pgalloc_pkg::cmd_e    cmd_i,
  input  logic [31:0]          addr_i,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  output logic                 valid_o,
  output logic [31:0]          page_addr_o,
  output logic [7:0]           ref_count_o,
  output logic                 released_o,
  output pgalloc_pkg::status_e status_o
);
  import pgalloc_pkg::*;

  logic [31:0] base_q, first_q, top_q;
  logic        clearing, pop, head_valid;
  item_t       head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= 32'h8000_0000;
      first_q <= 32'h8000_0000;
      top_q   <= 32'h8800_0000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TABLE_BASE:   base_q  <= cfg_data_i;
        REG_FIRST_USABLE: first_q <= cfg_data_i;
        REG_TOP:          top_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pgalloc_front #(.NUM_PAGES(NUM_PAGES), .PAGE_SHIFT(PAGE_SHIFT)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .addr_i         (addr_i),
    .base_i         (base_q),
    .first_usable_i (first_q),
    .top_i          (top_q),
    .clearing_i     (clearing),
    .pop_i          (pop),
    .head_valid_o   (head_valid),
    .head_o         (head)
  );

  pgalloc_back #(.NUM_PAGES(NUM_PAGES), .PAGE_SHIFT(PAGE_SHIFT)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .base_i       (base_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .valid_o      (valid_o),
    .page_addr_o  (page_addr_o),
    .ref_count_o  (ref_count_o),
    .released_o   (released_o),
    .status_o     (status_o)
  );

endmodule
